[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion helpers for the bitrate selector RTL (included by mbs_ctrl)
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while aresetn is low.
`define MBS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while aresetn is low.
`define MBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/mbs_pkg.sv]
// ---------------------------------------------------------------------------
// mbs_pkg
// Shared constants, codes and bundles of the bitrate selector.
// ---------------------------------------------------------------------------
`default_nettype none

package mbs_pkg;

    localparam int LEVELS       = 8;
    localparam int SEARCH_DEPTH = 4;
    localparam int ERROR_WINDOW = 5;

    localparam int Q_W    = 3;
    localparam int D_W    = (SEARCH_DEPTH > 1) ? $clog2(SEARCH_DEPTH) : 1;
    localparam int WIN_W  = (ERROR_WINDOW > 1) ? $clog2(ERROR_WINDOW) : 1;
    localparam int FILL_W = $clog2(ERROR_WINDOW + 1);

    localparam int RATE_W  = 16;
    localparam int TM_W    = 41;
    localparam int BUF_W   = 44;
    localparam int SCORE_W = 52;

    localparam int DVD_W = 64;
    localparam int DVS_W = 33;
    localparam int CNT_W = 7;

    localparam logic [TM_W-1:0] TIME_CAP = {1'b1, {(TM_W-1){1'b0}}};

    typedef enum logic [1:0] {
        OP_DECIDE     = 2'd0,
        OP_DOWNLOAD   = 2'd1,
        OP_PAUSE      = 2'd2,
        OP_SET_BUFFER = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        CFG_SEG_DUR   = 3'd0,
        CFG_BUF_CAP   = 3'd1,
        CFG_LEVEL_CNT = 3'd2,
        CFG_RATE_LO   = 3'd3,
        CFG_RATE_HI   = 3'd4
    } cfg_idx_t;

    typedef enum logic [4:0] {
        CMD_IDLE,
        CMD_LOAD,
        CMD_TPUT_START,
        CMD_TPUT_TAKE,
        CMD_MUL,
        CMD_TIME_START,
        CMD_TIME_TAKE,
        CMD_SRCH_INIT,
        CMD_SRCH_STEP,
        CMD_DEC_END,
        CMD_MEAS_START,
        CMD_MEAS_TAKE,
        CMD_ERR_START,
        CMD_ERR_TAKE,
        CMD_WIN_UPDATE,
        CMD_PAUSE_APPLY,
        CMD_SET_BUFFER,
        CMD_OUT_LOAD
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic lvl_last;
        logic srch_last;
    } st_t;

    typedef struct packed {
        logic [31:0]    seg_dur;
        logic [31:0]    buf_cap;
        logic [Q_W-1:0] n_last;
        logic [63:0]    rate_lo;
        logic [63:0]    rate_hi;
    } cfg_t;

endpackage

`default_nettype wire

[hdl/mbs_divider.sv]
// ---------------------------------------------------------------------------
// mbs_divider
// Shared restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module mbs_divider (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [mbs_pkg::DVD_W-1:0]  dividend,
    input  wire logic [mbs_pkg::DVS_W-1:0]  divisor,
    output logic                            done,
    output logic [mbs_pkg::DVD_W-1:0]       quotient
);

    logic                        busy_reg;
    logic                        done_reg;
    logic [mbs_pkg::CNT_W-1:0]   cnt_reg;
    logic [mbs_pkg::DVD_W-1:0]   quo_reg;
    logic [mbs_pkg::DVS_W:0]     rem_reg;
    logic [mbs_pkg::DVS_W-1:0]   dvs_reg;

    logic [mbs_pkg::DVS_W:0]     rem_sh;
    logic                        ge;
    logic [mbs_pkg::DVS_W:0]     rem_next;

    always_comb begin
        rem_sh   = {rem_reg[mbs_pkg::DVS_W-1:0], quo_reg[mbs_pkg::DVD_W-1]};
        ge       = (rem_sh >= {1'b0, dvs_reg});
        rem_next = ge ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[mbs_pkg::DVD_W-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == mbs_pkg::CNT_W'(mbs_pkg::DVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

[hdl/mbs_datapath.sv]
// ---------------------------------------------------------------------------
// mbs_datapath
// State registers, divider, per-level time table and the search engine.
// ---------------------------------------------------------------------------
`default_nettype none

module mbs_datapath (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire mbs_pkg::cmd_t        cmd,
    input  wire mbs_pkg::cfg_t        cfg,
    input  wire logic [15:0]          s_throughput_kbps,
    input  wire logic [31:0]          s_segment_bytes,
    input  wire logic [31:0]          s_elapsed_ms,
    input  wire logic [31:0]          s_pause_amount,
    input  wire logic signed [31:0]   s_new_buffer_level,
    output mbs_pkg::st_t              st,
    output logic [2:0]                m_chosen_quality,
    output logic [31:0]               m_pause_out,
    output logic signed [31:0]        m_buffer_level_out
);

    localparam int QW = mbs_pkg::Q_W;
    localparam int DW = mbs_pkg::D_W;
    localparam int BW = mbs_pkg::BUF_W;
    localparam int SW = mbs_pkg::SCORE_W;
    localparam int ND = mbs_pkg::SEARCH_DEPTH;
    localparam int NW = mbs_pkg::ERROR_WINDOW;

    function automatic logic [15:0] rate_of(input logic [63:0] lo, input logic [63:0] hi,
                                            input logic [QW-1:0] q);
        logic [63:0] t;
        t = q[2] ? hi : lo;
        return t[16*q[1:0] +: 16];
    endfunction

    // architectural state
    logic signed [31:0]           buf_lvl_reg;
    logic [QW-1:0]                last_q_reg;
    logic [15:0]                  est_tput_reg;
    logic [31:0]                  worst_reg;
    logic [31:0]                  last_pause_reg;
    logic [mbs_pkg::FILL_W-1:0]   fill_reg;
    logic [mbs_pkg::WIN_W-1:0]    next_reg;
    logic [31:0]                  win_reg [NW];

    // latched item fields and work registers
    logic [15:0]                  thr_reg;
    logic [31:0]                  bytes_reg;
    logic [31:0]                  ms_reg;
    logic [31:0]                  pause_reg;
    logic signed [31:0]           nbuf_reg;
    logic [31:0]                  tput_reg;
    logic [47:0]                  prod_reg;
    logic [QW-1:0]                lvl_idx_reg;
    logic [mbs_pkg::TM_W-1:0]     tm_reg [mbs_pkg::LEVELS];
    logic [15:0]                  meas_reg;

    // search engine
    logic [DW-1:0]                depth_reg;
    logic [QW-1:0]                cur_q_reg;
    logic                         pop_reg;
    logic                         first_reg;
    logic signed [SW-1:0]         best_reg;
    logic [QW-1:0]                choice_reg;
    logic [15:0]                  root_br_reg;
    logic [QW-1:0]                q_stk   [ND];
    logic [15:0]                  br_stk  [ND];
    logic signed [BW-1:0]         buf_stk [ND];
    logic signed [SW-1:0]         acc_stk [ND];

    // output register
    logic [2:0]                   out_q_reg;
    logic [31:0]                  out_pause_reg;
    logic signed [31:0]           out_buf_reg;

    // divider
    logic                         div_start;
    logic [mbs_pkg::DVD_W-1:0]    div_dvd;
    logic [mbs_pkg::DVS_W-1:0]    div_dvs;
    logic                         div_done;
    logic [mbs_pkg::DVD_W-1:0]    div_quo;

    logic [15:0]                  diff16;
    logic [31:0]                  ms_fix;

    mbs_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb begin
        diff16 = (est_tput_reg > meas_reg) ? (est_tput_reg - meas_reg)
                                           : (meas_reg - est_tput_reg);
        ms_fix = (ms_reg == 32'd0) ? 32'd1 : ms_reg;
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = '0;
        case (cmd)
            mbs_pkg::CMD_TPUT_START: begin
                div_start = 1'b1;
                div_dvd   = {16'd0, thr_reg, 32'd0};
                div_dvs   = {1'b0, worst_reg} + 33'd65536;
            end
            mbs_pkg::CMD_TIME_START: begin
                div_start = 1'b1;
                div_dvd   = {prod_reg, 16'd0};
                div_dvs   = {1'b0, tput_reg};
            end
            mbs_pkg::CMD_MEAS_START: begin
                div_start = 1'b1;
                div_dvd   = {29'd0, bytes_reg, 3'd0};
                div_dvs   = {1'b0, ms_fix};
            end
            mbs_pkg::CMD_ERR_START: begin
                div_start = 1'b1;
                div_dvd   = {32'd0, diff16, 16'd0};
                div_dvs   = {17'd0, meas_reg};
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // one node of the search tree
    logic [QW-1:0]          rate_idx;
    logic [15:0]            cur_br;
    logic [15:0]            prev_br;
    logic [DW-1:0]          par_idx;
    logic signed [BW-1:0]   buf_in;
    logic signed [SW-1:0]   acc_in;
    logic signed [BW-1:0]   seg_x;
    logic signed [BW-1:0]   cap_x;
    logic signed [BW-1:0]   b1;
    logic signed [BW-1:0]   b2;
    logic signed [BW-1:0]   rebuf;
    logic signed [BW-1:0]   buf_out;
    logic signed [16:0]     rdiff;
    logic signed [16:0]     rneg;
    logic [15:0]            abs_d;
    logic signed [16:0]     rpart;
    logic signed [SW-1:0]   rate_val;
    logic signed [SW-1:0]   rb_x;
    logic signed [SW-1:0]   acc_out;
    logic                   is_leaf;
    logic                   at_last;

    always_comb begin
        case (cmd)
            mbs_pkg::CMD_SRCH_INIT: rate_idx = last_q_reg;
            mbs_pkg::CMD_MUL:       rate_idx = lvl_idx_reg;
            default:                rate_idx = cur_q_reg;
        endcase
        cur_br  = rate_of(cfg.rate_lo, cfg.rate_hi, rate_idx);
        par_idx = depth_reg - 1'b1;
        if (depth_reg == '0) begin
            buf_in  = $signed({{(BW-32){buf_lvl_reg[31]}}, buf_lvl_reg});
            prev_br = root_br_reg;
            acc_in  = '0;
        end else begin
            buf_in  = buf_stk[par_idx];
            prev_br = br_stk[par_idx];
            acc_in  = acc_stk[par_idx];
        end
        seg_x = $signed({{(BW-32){1'b0}}, cfg.seg_dur});
        cap_x = $signed({{(BW-32){1'b0}}, cfg.buf_cap});
        b1 = ((buf_in + seg_x) > cap_x) ? (cap_x - seg_x) : buf_in;
        b2 = b1 - $signed({{(BW-mbs_pkg::TM_W){1'b0}}, tm_reg[cur_q_reg]});
        if (b2 < 0) begin
            rebuf   = -b2;
            buf_out = seg_x;
        end else begin
            rebuf   = '0;
            buf_out = b2 + seg_x;
        end
        rdiff    = $signed({1'b0, cur_br}) - $signed({1'b0, prev_br});
        rneg     = -rdiff;
        abs_d    = rdiff[16] ? rneg[15:0] : rdiff[15:0];
        rpart    = $signed({1'b0, cur_br}) - $signed({1'b0, abs_d});
        rate_val = $signed({{(SW-33){rpart[16]}}, rpart, 16'd0});
        rb_x     = $signed({{(SW-BW){1'b0}}, rebuf});
        acc_out  = acc_in + rate_val - ((rb_x <<< 1) + rb_x);
        is_leaf  = (depth_reg == DW'(ND - 1));
        at_last  = (cur_q_reg == cfg.n_last);
    end

    // per-command results
    logic signed [33:0]  pause_p;
    logic signed [33:0]  pause_d;
    logic [32:0]         dl_sum;
    logic [31:0]         err_val;
    logic [31:0]         worst_w;

    always_comb begin
        pause_p = $signed({{2{buf_lvl_reg[31]}}, buf_lvl_reg})
                + $signed({2'b00, cfg.seg_dur}) - $signed({2'b00, cfg.buf_cap});
        pause_d = $signed({{2{buf_lvl_reg[31]}}, buf_lvl_reg}) - $signed({2'b00, pause_reg});
        dl_sum  = {2'b00, (buf_lvl_reg[31] ? 31'd0 : buf_lvl_reg[30:0])}
                + {1'b0, cfg.seg_dur};
        if (meas_reg == 16'd0) begin
            err_val = 32'hFFFF_FFFF;
        end else if (div_quo > 64'h0000_0000_FFFF_FFFF) begin
            err_val = 32'hFFFF_FFFF;
        end else begin
            err_val = div_quo[31:0];
        end
        worst_w = '0;
        for (int i = 0; i < NW; i++) begin
            if ((mbs_pkg::FILL_W'(i) < fill_reg) && (win_reg[i] > worst_w)) begin
                worst_w = win_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_lvl_reg    <= '0;
            last_q_reg     <= '0;
            est_tput_reg   <= '0;
            worst_reg      <= '0;
            last_pause_reg <= '0;
            fill_reg       <= '0;
            next_reg       <= '0;
        end else begin
            case (cmd)
                mbs_pkg::CMD_LOAD: begin
                    thr_reg   <= s_throughput_kbps;
                    bytes_reg <= s_segment_bytes;
                    ms_reg    <= s_elapsed_ms;
                    pause_reg <= s_pause_amount;
                    nbuf_reg  <= s_new_buffer_level;
                end
                mbs_pkg::CMD_TPUT_TAKE: begin
                    tput_reg    <= (div_quo[31:0] == 32'd0) ? 32'd1 : div_quo[31:0];
                    lvl_idx_reg <= '0;
                end
                mbs_pkg::CMD_MUL: begin
                    prod_reg <= cur_br * cfg.seg_dur;
                end
                mbs_pkg::CMD_TIME_TAKE: begin
                    tm_reg[lvl_idx_reg] <= (div_quo > mbs_pkg::DVD_W'(mbs_pkg::TIME_CAP))
                                           ? mbs_pkg::TIME_CAP
                                           : div_quo[mbs_pkg::TM_W-1:0];
                    lvl_idx_reg <= lvl_idx_reg + 1'b1;
                end
                mbs_pkg::CMD_SRCH_INIT: begin
                    depth_reg   <= '0;
                    cur_q_reg   <= '0;
                    pop_reg     <= 1'b0;
                    first_reg   <= 1'b1;
                    root_br_reg <= cur_br;
                end
                mbs_pkg::CMD_SRCH_STEP: begin
                    if (!pop_reg) begin
                        if (!is_leaf) begin
                            q_stk[depth_reg]   <= cur_q_reg;
                            br_stk[depth_reg]  <= cur_br;
                            buf_stk[depth_reg] <= buf_out;
                            acc_stk[depth_reg] <= acc_out;
                            depth_reg          <= depth_reg + 1'b1;
                            cur_q_reg          <= '0;
                        end else begin
                            if (first_reg || (acc_out > best_reg)) begin
                                best_reg   <= acc_out;
                                choice_reg <= (depth_reg == '0) ? cur_q_reg : q_stk[0];
                            end
                            first_reg <= 1'b0;
                            if (!at_last) begin
                                cur_q_reg <= cur_q_reg + 1'b1;
                            end else if (depth_reg != '0) begin
                                depth_reg <= par_idx;
                                cur_q_reg <= q_stk[par_idx];
                                pop_reg   <= 1'b1;
                            end
                        end
                    end else begin
                        if (!at_last) begin
                            cur_q_reg <= cur_q_reg + 1'b1;
                            pop_reg   <= 1'b0;
                        end else if (depth_reg != '0) begin
                            depth_reg <= par_idx;
                            cur_q_reg <= q_stk[par_idx];
                        end
                    end
                end
                mbs_pkg::CMD_DEC_END: begin
                    last_q_reg   <= choice_reg;
                    est_tput_reg <= thr_reg;
                    if (pause_p < 0) begin
                        last_pause_reg <= '0;
                    end else if (pause_p[32]) begin
                        last_pause_reg <= 32'hFFFF_FFFF;
                    end else begin
                        last_pause_reg <= pause_p[31:0];
                    end
                end
                mbs_pkg::CMD_MEAS_TAKE: begin
                    meas_reg <= (div_quo > 64'd65535) ? 16'hFFFF : div_quo[15:0];
                end
                mbs_pkg::CMD_ERR_TAKE: begin
                    win_reg[next_reg] <= err_val;
                    next_reg <= (next_reg == mbs_pkg::WIN_W'(NW - 1)) ? '0 : next_reg + 1'b1;
                    if (fill_reg < mbs_pkg::FILL_W'(NW)) begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                end
                mbs_pkg::CMD_WIN_UPDATE: begin
                    worst_reg   <= worst_w;
                    buf_lvl_reg <= (dl_sum > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                               : $signed(dl_sum[31:0]);
                end
                mbs_pkg::CMD_PAUSE_APPLY: begin
                    buf_lvl_reg <= (pause_d < -34'sd2147483648) ? 32'sh8000_0000
                                                                 : pause_d[31:0];
                end
                mbs_pkg::CMD_SET_BUFFER: begin
                    buf_lvl_reg <= nbuf_reg;
                end
                mbs_pkg::CMD_OUT_LOAD: begin
                    out_q_reg     <= last_q_reg;
                    out_pause_reg <= last_pause_reg;
                    out_buf_reg   <= buf_lvl_reg;
                end
                default: begin
                end
            endcase
        end
    end

    assign st.div_done  = div_done;
    assign st.lvl_last  = (lvl_idx_reg == cfg.n_last);
    assign st.srch_last = (pop_reg || is_leaf) && at_last && (depth_reg == '0);

    assign m_chosen_quality   = out_q_reg;
    assign m_pause_out        = out_pause_reg;
    assign m_buffer_level_out = out_buf_reg;

endmodule

`default_nettype wire

[hdl/mbs_ctrl.sv]
// ---------------------------------------------------------------------------
// mbs_ctrl
// Sequencer: issues one datapath command per cycle, owns both handshakes.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mbs_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [1:0]    s_opcode,
    output logic               m_valid,
    input  wire logic          m_ready,
    input  wire mbs_pkg::st_t  st,
    output mbs_pkg::cmd_t      cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_TPUT_GO,
        S_TPUT_WAIT,
        S_TPUT_TAKE,
        S_MUL,
        S_TIME_GO,
        S_TIME_WAIT,
        S_TIME_TAKE,
        S_SRCH_INIT,
        S_SRCH,
        S_DEC_END,
        S_MEAS_GO,
        S_MEAS_WAIT,
        S_MEAS_TAKE,
        S_ERR_GO,
        S_ERR_WAIT,
        S_ERR_TAKE,
        S_WIN,
        S_PAUSE,
        S_SETBUF,
        S_OUT
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        unique case (state_reg)
            S_IDLE:      cmd = s_valid ? mbs_pkg::CMD_LOAD : mbs_pkg::CMD_IDLE;
            S_TPUT_GO:   cmd = mbs_pkg::CMD_TPUT_START;
            S_TPUT_TAKE: cmd = mbs_pkg::CMD_TPUT_TAKE;
            S_MUL:       cmd = mbs_pkg::CMD_MUL;
            S_TIME_GO:   cmd = mbs_pkg::CMD_TIME_START;
            S_TIME_TAKE: cmd = mbs_pkg::CMD_TIME_TAKE;
            S_SRCH_INIT: cmd = mbs_pkg::CMD_SRCH_INIT;
            S_SRCH:      cmd = mbs_pkg::CMD_SRCH_STEP;
            S_DEC_END:   cmd = mbs_pkg::CMD_DEC_END;
            S_MEAS_GO:   cmd = mbs_pkg::CMD_MEAS_START;
            S_MEAS_TAKE: cmd = mbs_pkg::CMD_MEAS_TAKE;
            S_ERR_GO:    cmd = mbs_pkg::CMD_ERR_START;
            S_ERR_TAKE:  cmd = mbs_pkg::CMD_ERR_TAKE;
            S_WIN:       cmd = mbs_pkg::CMD_WIN_UPDATE;
            S_PAUSE:     cmd = mbs_pkg::CMD_PAUSE_APPLY;
            S_SETBUF:    cmd = mbs_pkg::CMD_SET_BUFFER;
            S_OUT:       cmd = out_free ? mbs_pkg::CMD_OUT_LOAD : mbs_pkg::CMD_IDLE;
            default:     cmd = mbs_pkg::CMD_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        unique case (s_opcode)
                            mbs_pkg::OP_DECIDE:   state_reg <= S_TPUT_GO;
                            mbs_pkg::OP_DOWNLOAD: state_reg <= S_MEAS_GO;
                            mbs_pkg::OP_PAUSE:    state_reg <= S_PAUSE;
                            default:              state_reg <= S_SETBUF;
                        endcase
                    end
                end
                S_TPUT_GO:   state_reg <= S_TPUT_WAIT;
                S_TPUT_WAIT: if (st.div_done) state_reg <= S_TPUT_TAKE;
                S_TPUT_TAKE: state_reg <= S_MUL;
                S_MUL:       state_reg <= S_TIME_GO;
                S_TIME_GO:   state_reg <= S_TIME_WAIT;
                S_TIME_WAIT: if (st.div_done) state_reg <= S_TIME_TAKE;
                S_TIME_TAKE: state_reg <= st.lvl_last ? S_SRCH_INIT : S_MUL;
                S_SRCH_INIT: state_reg <= S_SRCH;
                S_SRCH:      if (st.srch_last) state_reg <= S_DEC_END;
                S_DEC_END:   state_reg <= S_OUT;
                S_MEAS_GO:   state_reg <= S_MEAS_WAIT;
                S_MEAS_WAIT: if (st.div_done) state_reg <= S_MEAS_TAKE;
                S_MEAS_TAKE: state_reg <= S_ERR_GO;
                S_ERR_GO:    state_reg <= S_ERR_WAIT;
                S_ERR_WAIT:  if (st.div_done) state_reg <= S_ERR_TAKE;
                S_ERR_TAKE:  state_reg <= S_WIN;
                S_WIN:       state_reg <= S_OUT;
                S_PAUSE:     state_reg <= S_OUT;
                S_SETBUF:    state_reg <= S_OUT;
                S_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default:     state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    `MBS_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready,
                     "input taken while an item is still in work")
    `MBS_ASSERT_IMPL(a_word_from_out, $rose(m_valid), $past(state_reg == S_OUT),
                     "result word raised outside the output state")
    `MBS_ASSERT_IMPL(a_div_done_waited, st.div_done,
                     state_reg == S_TPUT_WAIT || state_reg == S_TIME_WAIT ||
                     state_reg == S_MEAS_WAIT || state_reg == S_ERR_WAIT,
                     "divider finished with no state waiting for it")

endmodule

`default_nettype wire

[hdl/mpc_bitrate_selector_core.sv]
// ---------------------------------------------------------------------------
// mpc_bitrate_selector_core
// Robust model-predictive bitrate chooser: config registers, sequencer and
// datapath with a shared divider and an exhaustive depth-first search.
// ---------------------------------------------------------------------------
//
//  channel   | handshake           | payload
//  ----------+---------------------+--------------------------------------------
//  s_ (in)   | s_valid / s_ready   | opcode, throughput, bytes, ms, pause, level
//  m_ (out)  | m_valid / m_ready   | chosen_quality, pause_out, buffer_level_out
//  cfg       | cfg_wr_en           | cfg_index, cfg_wdata (no read-back)
//
//  Sequencing: one word at a time. Decide runs the shared divider once for
//  the throughput estimate and once per level in use for the time table, then
//  the search over N = n + n^2 + n^3 + n^4 nodes (one per cycle) for n levels
//  in use, plus backtrack steps. Download runs the divider twice; pause and
//  set-buffer need no division. The divider and the search set the run time.
//  Reset: synchronous, aresetn low; state clears at once, no clearing pass.
//  Stalls: a held result word does not block acceptance of the next input;
//  only its completion waits for the output register to free up.
// ---------------------------------------------------------------------------
`default_nettype none

module mpc_bitrate_selector_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // configuration write port
    input  wire logic               cfg_wr_en,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [63:0]        cfg_wdata,
    // input word
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_opcode,
    input  wire logic [15:0]        s_throughput_kbps,
    input  wire logic [31:0]        s_segment_bytes,
    input  wire logic [31:0]        s_elapsed_ms,
    input  wire logic [31:0]        s_pause_amount,
    input  wire logic signed [31:0] s_new_buffer_level,
    // result word
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [2:0]              m_chosen_quality,
    output logic [31:0]             m_pause_out,
    output logic signed [31:0]      m_buffer_level_out
);

    // configuration registers
    logic [31:0] seg_dur_reg;
    logic [31:0] buf_cap_reg;
    logic [3:0]  level_cnt_reg;
    logic [63:0] rate_lo_reg;
    logic [63:0] rate_hi_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_dur_reg   <= 32'd262144;
            buf_cap_reg   <= 32'd1966080;
            level_cnt_reg <= 4'd1;
            rate_lo_reg   <= '0;
            rate_hi_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                mbs_pkg::CFG_SEG_DUR:   seg_dur_reg   <= cfg_wdata[31:0];
                mbs_pkg::CFG_BUF_CAP:   buf_cap_reg   <= cfg_wdata[31:0];
                mbs_pkg::CFG_LEVEL_CNT: level_cnt_reg <= cfg_wdata[3:0];
                mbs_pkg::CFG_RATE_LO:   rate_lo_reg   <= cfg_wdata;
                mbs_pkg::CFG_RATE_HI:   rate_hi_reg   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // level count: zero acts as one, anything above the table size as the
    // full table; the datapath sees the index of the last level in use
    mbs_pkg::cfg_t cfg;
    logic [mbs_pkg::Q_W-1:0] n_last;

    always_comb begin
        if (level_cnt_reg == 4'd0) begin
            n_last = '0;
        end else if (level_cnt_reg > 4'(mbs_pkg::LEVELS)) begin
            n_last = mbs_pkg::Q_W'(mbs_pkg::LEVELS - 1);
        end else begin
            n_last = mbs_pkg::Q_W'(level_cnt_reg - 4'd1);
        end
        cfg.seg_dur = seg_dur_reg;
        cfg.buf_cap = buf_cap_reg;
        cfg.n_last  = n_last;
        cfg.rate_lo = rate_lo_reg;
        cfg.rate_hi = rate_hi_reg;
    end

    mbs_pkg::cmd_t cmd;
    mbs_pkg::st_t  st;

    mbs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_opcode (s_opcode),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .st       (st),
        .cmd      (cmd)
    );

    mbs_datapath u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .cfg                (cfg),
        .s_throughput_kbps  (s_throughput_kbps),
        .s_segment_bytes    (s_segment_bytes),
        .s_elapsed_ms       (s_elapsed_ms),
        .s_pause_amount     (s_pause_amount),
        .s_new_buffer_level (s_new_buffer_level),
        .st                 (st),
        .m_chosen_quality   (m_chosen_quality),
        .m_pause_out        (m_pause_out),
        .m_buffer_level_out (m_buffer_level_out)
    );

endmodule

`default_nettype wire
